/* sv/jse_pkg.sv */
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; used by every module of the block.
package jse_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [6:0] CH_QUOTE  = 7'h22;
	localparam logic [6:0] CH_BSLASH = 7'h5C;
	localparam logic [6:0] CH_U      = 7'h75;
	localparam logic [6:0] CH_N      = 7'h6E;
	localparam logic [6:0] CH_R      = 7'h72;
	localparam logic [6:0] CH_T      = 7'h74;
	localparam logic [6:0] CH_NUL    = 7'h00;

	localparam logic [7:0] B_QUOTE  = 8'h22;
	localparam logic [7:0] B_BSLASH = 8'h5C;
	localparam logic [7:0] B_LF     = 8'h0A;
	localparam logic [7:0] B_CR     = 8'h0D;
	localparam logic [7:0] B_TAB    = 8'h09;
	localparam logic [7:0] B_DEL    = 8'h7F;

	// what the back end emits after the optional opening quote
	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_CHAR,
		BODY_ESC2,
		BODY_U1,
		BODY_U2,
		BODY_ERR
	} body_t;

	typedef struct packed {
		logic        quote;
		body_t       body;
		logic [6:0]  ch;
		logic        done;
		logic [15:0] v_hi;
		logic [15:0] v_lo;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	function automatic logic [6:0] hex_char(input logic [3:0] n);
		hex_char = (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h57 + {3'b000, n});
	endfunction

	function automatic logic [3:0] body_len(input body_t b);
		logic [3:0] len;
		unique case (b)
			BODY_CHAR: len = 4'd1;
			BODY_ESC2: len = 4'd2;
			BODY_U1:   len = 4'd6;
			BODY_U2:   len = 4'd12;
			BODY_ERR:  len = 4'd1;
			default:   len = 4'd0;
		endcase
		body_len = len;
	endfunction

endpackage

/* sv/jse_front.sv */
// Front end: takes input words, tracks UTF-8 decode state, builds at most one job per word.
// Depends on jse_pkg.
module jse_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      char_byte,
	input  logic            string_end,
	input  logic            full,
	output jse_pkg::push_t  push
);

	logic        in_string_q, in_string_n;
	logic [1:0]  pending_q, pending_n;
	logic [1:0]  seq_len_q, seq_len_n;
	logic [20:0] accum_q, accum_n;
	logic        skip_q, skip_n;

	logic        accept;
	logic [20:0] acc_cat;
	logic [25:0] u_off;
	jse_pkg::job_t job;
	logic        produce;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign acc_cat  = {accum_q[14:0], char_byte[5:0]};
	assign u_off    = {5'b00000, acc_cat} - 26'h0010000;

	always_comb begin
		in_string_n = in_string_q;
		pending_n   = pending_q;
		seq_len_n   = seq_len_q;
		accum_n     = accum_q;
		skip_n      = skip_q;
		job         = '0;
		job.body    = jse_pkg::BODY_NONE;
		produce     = 1'b0;
		if (skip_q) begin
			if (string_end) begin
				skip_n      = 1'b0;
				in_string_n = 1'b0;
				pending_n   = '0;
				seq_len_n   = '0;
				accum_n     = '0;
			end
		end else if (string_end) begin
			produce = 1'b1;
			if (pending_q != 2'd0) begin
				job.body = jse_pkg::BODY_ERR;
			end else begin
				job.quote = !in_string_q;
				job.body  = jse_pkg::BODY_CHAR;
				job.ch    = jse_pkg::CH_QUOTE;
				job.done  = 1'b1;
			end
			in_string_n = 1'b0;
			pending_n   = '0;
			seq_len_n   = '0;
			accum_n     = '0;
		end else if (pending_q != 2'd0) begin
			accum_n   = acc_cat;
			pending_n = pending_q - 2'd1;
			if (pending_q == 2'd1) begin
				produce = 1'b1;
				if (seq_len_q == 2'd3) begin
					job.body = jse_pkg::BODY_U2;
					job.v_hi = u_off[25:10] + 16'hD800;
					job.v_lo = {6'b110111, u_off[9:0]};
				end else begin
					job.body = jse_pkg::BODY_U1;
					job.v_hi = acc_cat[15:0];
				end
				accum_n   = '0;
				seq_len_n = '0;
			end
		end else begin
			job.quote   = !in_string_q;
			in_string_n = 1'b1;
			priority if (char_byte == jse_pkg::B_QUOTE || char_byte == jse_pkg::B_BSLASH) begin
				job.body = jse_pkg::BODY_ESC2;
				job.ch   = char_byte[6:0];
			end else if (char_byte == jse_pkg::B_LF) begin
				job.body = jse_pkg::BODY_ESC2;
				job.ch   = jse_pkg::CH_N;
			end else if (char_byte == jse_pkg::B_CR) begin
				job.body = jse_pkg::BODY_ESC2;
				job.ch   = jse_pkg::CH_R;
			end else if (char_byte == jse_pkg::B_TAB) begin
				job.body = jse_pkg::BODY_ESC2;
				job.ch   = jse_pkg::CH_T;
			end else if (char_byte <= 8'h1F || char_byte == jse_pkg::B_DEL) begin
				job.body = jse_pkg::BODY_U1;
				job.v_hi = {8'h00, char_byte};
			end else if (char_byte < 8'h80) begin
				job.body = jse_pkg::BODY_CHAR;
				job.ch   = char_byte[6:0];
			end else if ((char_byte & 8'hE0) == 8'hC0) begin
				accum_n   = {16'h0000, char_byte[4:0]};
				pending_n = 2'd1;
				seq_len_n = 2'd1;
			end else if ((char_byte & 8'hF0) == 8'hE0) begin
				accum_n   = {17'h00000, char_byte[3:0]};
				pending_n = 2'd2;
				seq_len_n = 2'd2;
			end else if ((char_byte & 8'hF8) == 8'hF0) begin
				accum_n   = {18'h00000, char_byte[2:0]};
				pending_n = 2'd3;
				seq_len_n = 2'd3;
			end else begin
				job.body    = jse_pkg::BODY_ERR;
				in_string_n = 1'b0;
				pending_n   = '0;
				seq_len_n   = '0;
				accum_n     = '0;
				skip_n      = 1'b1;
			end
			produce = job.quote || (job.body != jse_pkg::BODY_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			pending_q   <= '0;
			seq_len_q   <= '0;
			accum_q     <= '0;
			skip_q      <= 1'b0;
		end else if (accept) begin
			in_string_q <= in_string_n;
			pending_q   <= pending_n;
			seq_len_q   <= seq_len_n;
			accum_q     <= accum_n;
			skip_q      <= skip_n;
		end
	end

	assign push.push = accept && produce;
	assign push.job  = job;

endmodule

/* sv/jse_fifo.sv */
// Job queue between front and back ends.
// Depends on jse_pkg for the job type.
module jse_fifo #(
	parameter int DEPTH = jse_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  jse_pkg::push_t wr,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output jse_pkg::job_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = wr.push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/jse_back.sv */
// Back end: walks the head job one character per cycle, while the output is not stalled, into the output register.
// Depends on jse_pkg.
module jse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  jse_pkg::job_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [6:0]    out_char,
	output logic          run_last,
	output logic          string_done,
	output logic          encode_error
);

	logic [3:0]  idx_q;
	logic [3:0]  total, k, pos;
	logic        last;
	logic        adv;
	logic        valid_q;
	logic [6:0]  ch;
	logic        done, err;
	logic [15:0] v;
	logic [6:0]  char_q;
	logic        last_q, done_q, err_q;

	assign total = {3'b000, head.quote} + jse_pkg::body_len(head.body);
	assign last  = (idx_q == total - 4'd1);
	assign k     = idx_q - {3'b000, head.quote};
	assign pos   = (k >= 4'd6) ? (k - 4'd6) : k;
	assign v     = (k >= 4'd6) ? head.v_lo : head.v_hi;
	assign adv   = !valid_q || out_ready;
	assign pop   = adv && !empty && last;

	always_comb begin
		ch   = jse_pkg::CH_NUL;
		done = 1'b0;
		err  = 1'b0;
		if (head.quote && idx_q == 4'd0) begin
			ch = jse_pkg::CH_QUOTE;
		end else begin
			unique case (head.body)
				jse_pkg::BODY_CHAR: begin
					ch   = head.ch;
					done = head.done;
				end
				jse_pkg::BODY_ESC2: begin
					ch = (k == 4'd0) ? jse_pkg::CH_BSLASH : head.ch;
				end
				jse_pkg::BODY_U1, jse_pkg::BODY_U2: begin
					unique case (pos)
						4'd0:    ch = jse_pkg::CH_BSLASH;
						4'd1:    ch = jse_pkg::CH_U;
						4'd2:    ch = jse_pkg::hex_char(v[15:12]);
						4'd3:    ch = jse_pkg::hex_char(v[11:8]);
						4'd4:    ch = jse_pkg::hex_char(v[7:4]);
						default: ch = jse_pkg::hex_char(v[3:0]);
					endcase
				end
				jse_pkg::BODY_ERR: begin
					done = 1'b1;
					err  = 1'b1;
				end
				default: ch = jse_pkg::CH_NUL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !empty) begin
			char_q <= ch;
			last_q <= last;
			done_q <= done;
			err_q  <= err;
		end
	end

	assign out_valid    = valid_q;
	assign out_char     = char_q;
	assign run_last     = last_q;
	assign string_done  = done_q;
	assign encode_error = err_q;

endmodule

/* sv/json_string_escaper.sv */
// JSON string escaper: UTF-8 bytes in, quoted and escaped JSON text out, one char a word.
// Path: a taken word's job is written to the job queue, and its chars then pass through the output register.
// Throughput: one input word per cycle while each makes at most one char and the output
// is not stalled. A word making more chars (escape 2-3, \u00xx 6-7, surrogate pair 12)
// holds the back end meanwhile; the job queue lets the front take words until it fills.
// Reset: arst_n clears decode state, queue pointers and output valid at once.
module json_string_escaper #(
	parameter int FIFO_DEPTH = jse_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_byte
	input  logic       s_tlast,  // string_end
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [6:0] out_char, [7] zero
	output logic       m_tlast,  // run_last: final char caused by one input word
	output logic [1:0] m_tuser   // [0] string_done, [1] encode_error
);

	// front to queue: one job per input word that yields any output
	jse_pkg::push_t fifo_wr;
	jse_pkg::job_t  fifo_head;
	logic           fifo_full, fifo_empty, fifo_pop;
	logic [6:0]     out_char;
	logic           string_done, encode_error;

	// Front: decode state (in-string, pending continuation bytes, code point
	// accumulator, skip after error) and classification of each word.
	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_byte  (s_tdata),
		.string_end (s_tlast),
		.full       (fifo_full),
		.push       (fifo_wr)
	);

	// Short job queue so that front and back stall independently.
	jse_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fifo_wr),
		.pop    (fifo_pop),
		.full   (fifo_full),
		.empty  (fifo_empty),
		.head   (fifo_head)
	);

	// Back: expands the head job (quote, short escape, \uXXXX, pair, error)
	// one char per cycle, while the output is not stalled, into the registered output.
	jse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (fifo_empty),
		.head         (fifo_head),
		.pop          (fifo_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (out_char),
		.run_last     (m_tlast),
		.string_done  (string_done),
		.encode_error (encode_error)
	);

	assign m_tdata = {1'b0, out_char};
	assign m_tuser = {encode_error, string_done};

	// An error char ends both the string and its word, and carries no text.
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast && m_tdata == 8'h00)
		else $error("error char without done/last or with data");

	// A clean end of string is always the closing quote, last of its word.
	a_close_quote: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata == 8'h22 && m_tlast)
		else $error("string end not on closing quote");

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_wr.push |-> !fifo_full)
		else $error("job queue overflow");

endmodule

/* verif/json_string_escaper_tb.sv */
// Self-checking testbench for json_string_escaper: UTF-8 byte words in, JSON text words out.
// Builds its expected text with its own escaper model; depends on jse_pkg and the RTL only.
module json_string_escaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// stall watchdog, drain latency and receiver hold-off lengths in clock cycles
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 200;
	localparam int WORD_TARGET  = 360;

	localparam logic [31:0] SUPP_BASE = 32'h10000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;

	typedef struct {
		logic [7:0] b;
		logic       fin;    // end of string
		bit         drain;  // hold this word back until all expected text has come out
	} utf8_word_t;

	typedef struct {
		logic [6:0] ch;
		logic       last;
		logic       done;
		logic       err;
	} json_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	utf8_word_t utf8_q[$];       // words still to be offered
	json_char_t json_text_q[$];  // escaped text still to come out

	bit drain_next = 1'b0;
	bit hold_used  = 1'b0;
	int hold_left  = 0;
	int words_queued = 0;
	int words_in   = 0;
	int words_out  = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int step_chars;

	// escaper model state
	logic        str_open;
	logic [1:0]  cont_left;
	logic [1:0]  seq_cont;
	logic [20:0] code_bits;
	logic        skip_rest;

	json_string_escaper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] char_byte
		.s_tlast  (s_tlast),   // string_end
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [6:0] out_char, [7] zero
		.m_tlast  (m_tlast),   // run_last
		.m_tuser  (m_tuser)    // [0] string_done, [1] encode_error
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("mismatch at %0t ns, output word %0d: %s", $realtime, words_out, what);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------
	// Escaper model
	// ---------------------------------------------------------------------
	function automatic logic [6:0] hex_digit_of(input logic [3:0] v);
		if (v < 4'd10)
			return 7'h30 + 7'(v);
		return 7'h61 + 7'(v) - 7'd10;
	endfunction

	task automatic emit_char(input logic [6:0] ch, input logic done, input logic err);
		json_char_t c;
		c.ch   = ch;
		c.last = 1'b0;
		c.done = done;
		c.err  = err;
		json_text_q.push_back(c);
		step_chars++;
	endtask

	task automatic emit_u16(input logic [15:0] v);
		emit_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
		emit_char(jse_pkg::CH_U, 1'b0, 1'b0);
		for (int i = 3; i >= 0; i--)
			emit_char(hex_digit_of(v[i*4 +: 4]), 1'b0, 1'b0);
	endtask

	task automatic close_string();
		str_open  = 1'b0;
		cont_left = 2'd0;
		seq_cont  = 2'd0;
		code_bits = 21'd0;
	endtask

	task automatic escape_word(input logic [7:0] b, input logic fin);
		logic [31:0] u;
		logic [15:0] hi, lo;
		json_char_t c;
		step_chars = 0;
		if (skip_rest) begin
			// after a bad lead byte everything up to the end of string vanishes
			if (fin) begin
				skip_rest = 1'b0;
				close_string();
			end
		end else if (fin) begin
			if (cont_left != 2'd0) begin
				emit_char(jse_pkg::CH_NUL, 1'b1, 1'b1);  // string cut inside a sequence
			end else begin
				if (!str_open)
					emit_char(jse_pkg::CH_QUOTE, 1'b0, 1'b0);
				emit_char(jse_pkg::CH_QUOTE, 1'b1, 1'b0);
			end
			close_string();
		end else if (cont_left != 2'd0) begin
			// continuation bytes are taken on trust, only the low six bits count
			code_bits = {code_bits[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				if (seq_cont == 2'd3) begin
					u  = {11'd0, code_bits} - SUPP_BASE;
					hi = u[25:10] + HI_SURR;
					lo = {6'd0, u[9:0]} + LO_SURR;
					emit_u16(hi);
					emit_u16(lo);
				end else begin
					emit_u16(code_bits[15:0]);
				end
				code_bits = 21'd0;
				seq_cont  = 2'd0;
			end
		end else begin
			if (!str_open) begin
				emit_char(jse_pkg::CH_QUOTE, 1'b0, 1'b0);
				str_open = 1'b1;
			end
			if (b == jse_pkg::B_QUOTE || b == jse_pkg::B_BSLASH) begin
				emit_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
				emit_char(b[6:0], 1'b0, 1'b0);
			end else if (b == jse_pkg::B_LF) begin
				emit_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
				emit_char(jse_pkg::CH_N, 1'b0, 1'b0);
			end else if (b == jse_pkg::B_CR) begin
				emit_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
				emit_char(jse_pkg::CH_R, 1'b0, 1'b0);
			end else if (b == jse_pkg::B_TAB) begin
				emit_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
				emit_char(jse_pkg::CH_T, 1'b0, 1'b0);
			end else if (b <= 8'h1F || b == jse_pkg::B_DEL) begin
				emit_u16({8'h00, b});
			end else if (b < 8'h80) begin
				emit_char(b[6:0], 1'b0, 1'b0);
			end else if (b[7:5] == 3'b110) begin
				code_bits = {16'd0, b[4:0]};
				cont_left = 2'd1;
				seq_cont  = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				code_bits = {17'd0, b[3:0]};
				cont_left = 2'd2;
				seq_cont  = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				code_bits = {18'd0, b[2:0]};
				cont_left = 2'd3;
				seq_cont  = 2'd3;
			end else begin
				// stray continuation or 11111xxx where a lead byte belongs
				emit_char(jse_pkg::CH_NUL, 1'b1, 1'b1);
				close_string();
				skip_rest = 1'b1;
			end
		end
		if (step_chars > 0) begin
			c = json_text_q.pop_back();
			c.last = 1'b1;
			json_text_q.push_back(c);
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------------
	task automatic queue_word(input logic [7:0] b, input logic fin, input bit counts);
		utf8_word_t w;
		w.b     = b;
		w.fin   = fin;
		w.drain = drain_next;
		drain_next = 1'b0;
		utf8_q.push_back(w);
		if (counts)
			words_queued++;
	endtask

	// end-of-string words carry a random byte: it must be ignored
	task automatic queue_end();
		queue_word(8'($urandom_range(255)), 1'b1, 1'b1);
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return {2'b10, 6'($urandom_range(63))};
	endfunction

	function automatic logic [7:0] bad_lead();
		if ($urandom_range(1) == 0)
			return {2'b10, 6'($urandom_range(63))};
		return {5'b11111, 3'($urandom_range(7))};
	endfunction

	// Mostly well-formed UTF-8 with random content; now and then a cut sequence,
	// a bad lead byte or a byte of pure noise.
	task automatic queue_random_string();
		int nch, r, k, keep;
		logic [7:0] lead;
		nch = $urandom_range(8);
		for (int i = 0; i < nch; i++) begin
			r = $urandom_range(99);
			k = 0;
			if (r < 40) begin
				lead = 8'($urandom_range(8'h20, 8'h7E));
			end else if (r < 52) begin
				case ($urandom_range(6))
					0:       lead = jse_pkg::B_QUOTE;
					1:       lead = jse_pkg::B_BSLASH;
					2:       lead = jse_pkg::B_LF;
					3:       lead = jse_pkg::B_CR;
					4:       lead = jse_pkg::B_TAB;
					5:       lead = 8'($urandom_range(8'h1F));
					default: lead = jse_pkg::B_DEL;
				endcase
			end else if (r < 67) begin
				lead = {3'b110, 5'($urandom_range(31))};
				k = 1;
			end else if (r < 82) begin
				lead = {4'b1110, 4'($urandom_range(15))};
				k = 2;
			end else if (r < 95) begin
				lead = {5'b11110, 3'($urandom_range(7))};
				k = 3;
			end else if (r < 97) begin
				queue_word(bad_lead(), 1'b0, 1'b1);
				repeat ($urandom_range(2))
					queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
				queue_end();
				return;
			end else begin
				lead = 8'($urandom_range(255));
			end
			queue_word(lead, 1'b0, 1'b1);
			if (k > 0 && $urandom_range(24) == 0) begin
				// cut the sequence short and end the string there
				keep = $urandom_range(k - 1);
				for (int j = 0; j < keep; j++)
					queue_word(cont_byte(), 1'b0, 1'b1);
				queue_end();
				return;
			end
			for (int j = 0; j < k; j++)
				queue_word(cont_byte(), 1'b0, 1'b1);
		end
		queue_end();
	endtask

	function automatic bit calm_window();
		return words_in >= 150 && words_in < 230;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers one word at a time, keeps it up until taken
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drive
		utf8_word_t nxt;
		bit pause;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				escape_word(s_tdata, s_tlast);
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				pause = hold_left == 0 && !calm_window() && $urandom_range(99) < 30;
				if (utf8_q.size() != 0 && utf8_q[0].drain && json_text_q.size() != 0)
					pause = 1'b1;
				if (utf8_q.size() != 0 && !pause) begin
					nxt = utf8_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.b;
					s_tlast  <= nxt.fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks every output word against the oldest expected char,
	// and drives the receiver's ready with random stalls and one long hold.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		json_char_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (json_text_q.size() == 0) begin
					report_mismatch($sformatf("word with nothing expected, tdata %h", m_tdata));
				end else begin
					e = json_text_q.pop_front();
					if (m_tdata !== {1'b0, e.ch})
						report_mismatch($sformatf("out_char %h, expected %h", m_tdata, e.ch));
					if (m_tlast !== e.last)
						report_mismatch($sformatf("run_last %b, expected %b", m_tlast, e.last));
					if (m_tuser[0] !== e.done)
						report_mismatch($sformatf("string_done %b, expected %b",
							m_tuser[0], e.done));
					if (m_tuser[1] !== e.err)
						report_mismatch($sformatf("encode_error %b, expected %b",
							m_tuser[1], e.err));
				end
				words_out++;
			end
			// one long hold-off early in the random part so the job queue fills up
			if (!hold_used && words_in >= 60) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm_window() || $urandom_range(99) >= 30;
			end
		end
	end

	// no handshake on either side for too long means the block has hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("json_string_escaper_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		str_open = 1'b0;
		skip_rest = 1'b0;
		close_string();

		// empty string: both quotes from the end word alone
		queue_end();
		// short escapes, controls, DEL, then 2-, 3- and overlong 4-byte sequences
		queue_word(jse_pkg::B_QUOTE, 1'b0, 1'b1);
		queue_word(jse_pkg::B_BSLASH, 1'b0, 1'b1);
		queue_word(jse_pkg::B_LF, 1'b0, 1'b1);
		queue_word(jse_pkg::B_CR, 1'b0, 1'b1);
		queue_word(jse_pkg::B_TAB, 1'b0, 1'b1);
		queue_word(8'h00, 1'b0, 1'b1);
		queue_word(8'h1F, 1'b0, 1'b1);
		queue_word(jse_pkg::B_DEL, 1'b0, 1'b1);
		queue_word(8'hC3, 1'b0, 1'b1);
		queue_word(8'hA9, 1'b0, 1'b1);
		queue_word(8'hE2, 1'b0, 1'b1);
		queue_word(8'h82, 1'b0, 1'b1);
		queue_word(8'hAC, 1'b0, 1'b1);
		// overlong 4-byte code: the surrogate arithmetic wraps
		queue_word(8'hF0, 1'b0, 1'b1);
		queue_word(8'h80, 1'b0, 1'b1);
		queue_word(8'h80, 1'b0, 1'b1);
		queue_word(8'h80, 1'b0, 1'b1);
		// bad lead mid-string, a byte that is skipped, then the end clears the skip
		queue_word(8'hFF, 1'b0, 1'b1);
		queue_word(8'h41, 1'b0, 1'b0);
		queue_end();
		// bad lead as the very first byte: opening quote, then the error
		queue_word(8'h80, 1'b0, 1'b1);
		queue_end();
		// sequence cut by the end of string
		queue_word(8'hE2, 1'b0, 1'b1);
		queue_word(8'h82, 1'b0, 1'b1);
		queue_end();

		// let the directed text drain completely before the random part
		drain_next = 1'b1;
		while (words_queued < WORD_TARGET) begin
			if ($urandom_range(14) == 0)
				drain_next = 1'b1;
			queue_random_string();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (utf8_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (json_text_q.size() != 0)
			@(posedge clk);
		// catch any stray word the block still has in flight
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("json_string_escaper_tb: done, clean");
		end else begin
			$display("json_string_escaper_tb: done, errors");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_fifo.sv
sv/jse_back.sv
sv/json_string_escaper.sv
verif/json_string_escaper_tb.sv
